// ===== hdl/color_temperature_gamma_ramp_assert.svh =====
// assertion macros for the colour temperature gamma ramp block
`ifndef COLOR_TEMPERATURE_GAMMA_RAMP_ASSERT_SVH
`define COLOR_TEMPERATURE_GAMMA_RAMP_ASSERT_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define CTGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent must follow the antecedent (non-overlapping implication)
`define CTGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CTGR_ASSERT_ALWAYS(lbl, prop, msg)
`define CTGR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/ctgr_pkg.sv =====
// constants, coefficient values and log table for the colour temperature gamma ramp
package ctgr_pkg;

  localparam int MAX_RAMP_ENTRIES = 4096;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] T_MIN   = 17'd700;
  localparam logic [16:0] T_NORM  = 17'd6500;
  localparam logic [16:0] T_HI_OFFSET = 17'd5800;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam logic signed [19:0] K0_GREEN_LO = -20'sd96830;
  localparam logic signed [16:0] K1_GREEN_LO = 17'sd18737;
  localparam logic signed [19:0] K0_BLUE_LO  = -20'sd287258;
  localparam logic signed [16:0] K1_BLUE_LO  = 17'sd40712;
  localparam logic signed [19:0] K0_RED_HI   = 20'sd114944;
  localparam logic signed [16:0] K1_RED_HI   = -17'sd7542;
  localparam logic signed [19:0] K0_GREEN_HI = 20'sd97794;
  localparam logic signed [16:0] K1_GREEN_HI = -17'sd4924;

  // register indexes on the apb port
  localparam logic [1:0] REG_TEMPERATURE = 2'd0;
  localparam logic [1:0] REG_BRIGHTNESS  = 2'd1;
  localparam logic [1:0] REG_RAMP_SIZE   = 2'd2;

  // round(65536*ln(1+k/16))
  function automatic logic [15:0] ln_table(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3973;
      5'd2:  v = 16'd7719;
      5'd3:  v = 16'd11262;
      5'd4:  v = 16'd14624;
      5'd5:  v = 16'd17821;
      5'd6:  v = 16'd20870;
      5'd7:  v = 16'd23783;
      5'd8:  v = 16'd26573;
      5'd9:  v = 16'd29248;
      5'd10: v = 16'd31818;
      5'd11: v = 16'd34292;
      5'd12: v = 16'd36675;
      5'd13: v = 16'd38975;
      5'd14: v = 16'd41196;
      5'd15: v = 16'd43345;
      5'd16: v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // q16 gain k0 + round(p / 65536), held to [0, 1.0]
  function automatic logic [16:0] gain_clamp(input logic signed [19:0] k0,
                                             input logic signed [37:0] p);
    logic signed [37:0] rnd;
    logic signed [38:0] g;
    logic [16:0] v;
    rnd = (p + 38'sd32768) >>> 16;
    g = 39'(k0) + 39'(rnd);
    if (g < 39'sd0) begin
      v = 17'd0;
    end else if (g > 39'sd65536) begin
      v = ONE_Q16;
    end else begin
      v = g[16:0];
    end
    return v;
  endfunction

endpackage

// ===== hdl/color_temperature_gamma_ramp.sv =====
// colour temperature gamma ramp generator: apb registers, 25-stage pipeline, skid output
//
// Usage: program temperature_kelvin (0x0), brightness_q16 (0x4) and ramp_size (0x8)
// through the apb port while no beat is in flight, then push ramp indexes on the in_
// channel. Each accepted index gives one beat on the out_ channel carrying the red,
// green and blue 16-bit ramp entries, in the order the indexes came in.
// Throughput: one index per clock while in_stall is low. The log lookup, gain
// multiplies and three entry multipliers take eight stages; each channel then runs a
// one-bit-per-stage restoring divider by the ramp size (one range check stage plus
// sixteen quotient stages).
// Reset (synchronous, rst_n low) empties the pipeline and loads 6500 K, brightness 1.0
// and a 256-entry ramp.
// When the receiver holds out_stall, the finished beat waits in the output register and
// one more beat drops into a skid register; only then does in_stall rise and the whole
// pipeline freeze until the output is taken. in_stall comes straight from a flop.
module color_temperature_gamma_ramp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_ramp_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red_entry,
  output logic [15:0] out_green_entry,
  output logic [15:0] out_blue_entry
);
  import ctgr_pkg::*;

  localparam int NSTG = 25;

  // configuration
  logic [16:0] temp_r;
  logic [16:0] bright_r;
  logic [12:0] size_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r   <= 17'd6500;
      bright_r <= 17'd65536;
      size_r   <= 13'd256;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TEMPERATURE: temp_r   <= pwdata[16:0];
        REG_BRIGHTNESS:  bright_r <= pwdata[16:0];
        REG_RAMP_SIZE:   size_r   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TEMPERATURE: prdata = {15'd0, temp_r};
      REG_BRIGHTNESS:  prdata = {15'd0, bright_r};
      REG_RAMP_SIZE:   prdata = {19'd0, size_r};
      default:         prdata = 32'd0;
    endcase
  end

  // settings only changed by user with pipeline empty, unenforced; stages read them live
  logic        lo_mode;
  logic        cold;
  logic [16:0] b_eff;
  logic [12:0] s_eff;

  assign lo_mode = temp_r < T_NORM;
  assign cold    = temp_r <= T_MIN;
  assign b_eff   = (bright_r > ONE_Q16) ? ONE_Q16 : bright_r;

  always_comb begin
    if (size_r == 13'd0) begin
      s_eff = 13'd1;
    end else if (32'(size_r) > MAX_RAMP_ENTRIES) begin
      s_eff = 13'(MAX_RAMP_ENTRIES);
    end else begin
      s_eff = size_r;
    end
  end

  // pipeline control
  logic            adv;
  logic            skid_v_r;
  logic            out_v_r;
  logic [NSTG-1:0] v_r;
  logic            in_acc;
  logic            out_take;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], in_acc};
    end
  end

  // stage 0: ln argument
  logic [16:0] s0_x_r;
  logic [11:0] s0_i_r;
  logic [16:0] x_nxt;

  always_comb begin
    if (!lo_mode) begin
      x_nxt = temp_r - T_HI_OFFSET;
    end else if (!cold) begin
      x_nxt = temp_r - T_MIN;
    end else begin
      x_nxt = 17'd1;
    end
  end

  // stage 1: normalise argument, brightness times index
  logic [4:0]  s1_e_r;
  logic [15:0] s1_f_r;
  logic [28:0] s1_bi_r;
  logic [4:0]  e_nxt;
  logic [32:0] m_c;

  always_comb begin
    e_nxt = 5'd0;
    for (int k = 0; k < 17; k++) begin
      if (s0_x_r[k]) begin
        e_nxt = 5'(k);
      end
    end
    m_c = {16'd0, s0_x_r} << (5'd16 - e_nxt);
  end

  // stage 2: table lookup and interpolation product
  logic [4:0]  s2_e_r;
  logic [15:0] s2_lo_r;
  logic [23:0] s2_prod_r;
  logic [28:0] s2_bi_r;
  logic [15:0] lo_c;
  logic [15:0] hi_c;
  logic [15:0] diff_c;

  assign lo_c   = ln_table({1'b0, s1_f_r[15:12]});
  assign hi_c   = ln_table({1'b0, s1_f_r[15:12]} + 5'd1);
  assign diff_c = hi_c - lo_c;

  // stage 3: ln in q16
  logic [19:0] s3_ln_r;
  logic [28:0] s3_bi_r;
  logic [19:0] ln_nxt;

  assign ln_nxt = 20'(s2_e_r) * 20'(LN2_Q16) + 20'(s2_lo_r)
                + 20'((25'(s2_prod_r) + 25'd2048) >> 12);

  // stage 4: slope times ln for the two computed gains
  logic signed [37:0] s4_pa_r;
  logic signed [37:0] s4_pb_r;
  logic [28:0]        s4_bi_r;
  logic signed [16:0] k1a_c;
  logic signed [16:0] k1b_c;
  logic signed [20:0] ln_s;
  logic signed [37:0] pa_nxt;
  logic signed [37:0] pb_nxt;

  assign k1a_c  = lo_mode ? K1_GREEN_LO : K1_RED_HI;
  assign k1b_c  = lo_mode ? K1_BLUE_LO  : K1_GREEN_HI;
  assign ln_s   = $signed({1'b0, s3_ln_r});
  assign pa_nxt = k1a_c * ln_s;
  assign pb_nxt = k1b_c * ln_s;

  // stage 5: gains per colour
  logic [16:0] s5_g_r [0:2];
  logic [28:0] s5_bi_r;
  logic [16:0] g_nxt  [0:2];
  logic [16:0] ga_c;
  logic [16:0] gb_c;

  always_comb begin
    ga_c = gain_clamp(lo_mode ? K0_GREEN_LO : K0_RED_HI, s4_pa_r);
    gb_c = gain_clamp(lo_mode ? K0_BLUE_LO  : K0_GREEN_HI, s4_pb_r);
    if (lo_mode) begin
      g_nxt[0] = ONE_Q16;
      g_nxt[1] = cold ? 17'd0 : ga_c;
      g_nxt[2] = cold ? 17'd0 : gb_c;
    end else begin
      g_nxt[0] = ga_c;
      g_nxt[1] = gb_c;
      g_nxt[2] = ONE_Q16;
    end
  end

  // stage 6: brightness*index*gain
  logic [45:0] s6_p_r [0:2];
  // stage 7: dividend with rounding, already scaled down by 2^32
  logic [29:0] s7_m_r [0:2];
  logic [61:0] sum_c  [0:2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = {s6_p_r[c], 16'd0} - {16'd0, s6_p_r[c]} + {18'd0, s_eff, 31'd0};
    end
  end

  // divider stages: index 0 checks range, index j yields quotient bit 16-j
  logic [28:0] rem_r   [0:2][0:15];
  logic [15:0] q_r     [0:2][0:16];
  logic        sat_r   [0:2][0:16];
  logic [28:0] rem_nxt [0:2][0:15];
  logic [15:0] q_nxt   [0:2][0:16];
  logic        sat_nxt [0:2][0:16];
  logic        ge_c    [0:2][1:16];
  logic [28:0] dv_c    [1:16];

  always_comb begin
    for (int j = 1; j <= 16; j++) begin
      dv_c[j] = {16'd0, s_eff} << (16 - j);
    end
    for (int c = 0; c < 3; c++) begin
      sat_nxt[c][0] = s7_m_r[c] >= {1'b0, s_eff, 16'd0};
      rem_nxt[c][0] = s7_m_r[c][28:0];
      q_nxt[c][0]   = 16'd0;
      for (int j = 1; j <= 16; j++) begin
        ge_c[c][j]    = rem_r[c][j-1] >= dv_c[j];
        sat_nxt[c][j] = sat_r[c][j-1];
        q_nxt[c][j]   = q_r[c][j-1] | (16'(ge_c[c][j]) << (16 - j));
      end
      for (int j = 1; j <= 15; j++) begin
        rem_nxt[c][j] = ge_c[c][j] ? rem_r[c][j-1] - dv_c[j] : rem_r[c][j-1];
      end
    end
  end

  // datapath registers, frozen together with the valid bits
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x_r    <= x_nxt;
      s0_i_r    <= in_ramp_index;
      s1_e_r    <= e_nxt;
      s1_f_r    <= m_c[15:0];
      s1_bi_r   <= 29'(b_eff) * 29'(s0_i_r);
      s2_e_r    <= s1_e_r;
      s2_lo_r   <= lo_c;
      s2_prod_r <= 24'(diff_c[11:0]) * 24'(s1_f_r[11:0]);
      s2_bi_r   <= s1_bi_r;
      s3_ln_r   <= ln_nxt;
      s3_bi_r   <= s2_bi_r;
      s4_pa_r   <= pa_nxt;
      s4_pb_r   <= pb_nxt;
      s4_bi_r   <= s3_bi_r;
      s5_bi_r   <= s4_bi_r;
      for (int c = 0; c < 3; c++) begin
        s5_g_r[c] <= g_nxt[c];
        s6_p_r[c] <= 46'(s5_bi_r) * 46'(s5_g_r[c]);
        s7_m_r[c] <= sum_c[c][61:32];
        for (int j = 0; j <= 16; j++) begin
          sat_r[c][j] <= sat_nxt[c][j];
          q_r[c][j]   <= q_nxt[c][j];
        end
        for (int j = 0; j <= 15; j++) begin
          rem_r[c][j] <= rem_nxt[c][j];
        end
      end
    end
  end

  // final stage result
  logic [15:0] res_c [0:2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res_c[c] = sat_r[c][16] ? 16'hFFFF : q_r[c][16];
    end
  end

  // output register and skid
  logic [15:0] out_d_r  [0:2];
  logic [15:0] skid_d_r [0:2];
  logic        pv;

  assign pv = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_take) begin
      out_v_r <= pv;
    end else if (pv) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_d_r <= skid_d_r;
      end
    end else if (!out_v_r || out_take) begin
      out_d_r <= res_c;
    end else if (pv) begin
      skid_d_r <= res_c;
    end
  end

  assign out_valid       = out_v_r;
  assign out_red_entry   = out_d_r[0];
  assign out_green_entry = out_d_r[1];
  assign out_blue_entry  = out_d_r[2];

  `include "color_temperature_gamma_ramp_assert.svh"

  `CTGR_ASSERT_ALWAYS(a_skid_needs_out, !skid_v_r || out_v_r, "skid full with output empty")
  `CTGR_ASSERT_NEXT(a_skid_catch, out_v_r && out_stall && !skid_v_r && pv, skid_v_r, "beat lost while output stalled")
  `CTGR_ASSERT_NEXT(a_skid_drain, skid_v_r && !out_stall, out_v_r && !skid_v_r, "skid beat not moved to output")
  `CTGR_ASSERT_ALWAYS(a_gain_range, !v_r[5] || (s5_g_r[0] <= ONE_Q16 && s5_g_r[1] <= ONE_Q16 && s5_g_r[2] <= ONE_Q16), "gain above one")

endmodule
